// ===== src/tcce_pkg.sv =====
// ----------------------------------------------------------------------------
// tcce_pkg: shared definitions for the text console cursor engine
// Command and character codes, the classified operation type, the item that
// travels from the front end to the back end, and default geometry.
// ----------------------------------------------------------------------------
package tcce_pkg;

  // Default geometry and queue depth.
  localparam int COLUMNS_DEF     = 80;
  localparam int ROWS_DEF        = 25;
  localparam int TAB_STOP_DEF    = 8;
  localparam int QUEUE_DEPTH_DEF = 2;

  // Port widths fixed by the command format.
  localparam int CMD_W  = 2;
  localparam int CHAR_W = 8;
  localparam int COLR_W = 4;
  localparam int ADDR_W = 11;
  localparam int CELL_W = 16;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  // Character codes with a special meaning.
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_DEL   = 8'h7F;

  // Blank cell: white on black space.
  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

  // Operation decided by the front end.
  typedef enum logic [2:0] {
    OP_NOP,
    OP_PRINT,
    OP_BS,
    OP_TAB,
    OP_CR,
    OP_LF,
    OP_CLEAR,
    OP_READ
  } op_t;

  // Classified item held in the queue.
  typedef struct packed {
    op_t                op;
    logic [CELL_W-1:0]  cell_word;
    logic [ADDR_W-1:0]  raddr;
  } item_t;

endpackage

// ===== src/tcce_front.sv =====
// ----------------------------------------------------------------------------
// tcce_front: command acceptance and classification
// Takes a command when the queue has room, decides which operation it is and
// builds the cell word for printable characters.
// ----------------------------------------------------------------------------
module tcce_front #(
  parameter int COLUMNS = tcce_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcce_pkg::ROWS_DEF
) (
  input  logic                        start,
  output logic                        busy,
  input  logic [tcce_pkg::CMD_W-1:0]  in_cmd,
  input  logic [tcce_pkg::CHAR_W-1:0] in_char_code,
  input  logic [tcce_pkg::COLR_W-1:0] in_back_color,
  input  logic [tcce_pkg::COLR_W-1:0] in_fore_color,
  input  logic [tcce_pkg::ADDR_W-1:0] in_read_addr,
  input  logic                        q_full,
  output logic                        q_push,
  output tcce_pkg::item_t             q_item
);

  localparam int CELLS = COLUMNS * ROWS;

  tcce_pkg::op_t put_op;
  logic          addr_ok;

  // A transfer happens whenever start is high and the queue can take the item.
  assign busy   = q_full;
  assign q_push = start && !q_full;

  // Character classification for the put command.
  always_comb begin
    priority if (in_char_code == tcce_pkg::CH_BS) begin
      put_op = tcce_pkg::OP_BS;
    end else if (in_char_code == tcce_pkg::CH_TAB) begin
      put_op = tcce_pkg::OP_TAB;
    end else if (in_char_code == tcce_pkg::CH_CR) begin
      put_op = tcce_pkg::OP_CR;
    end else if (in_char_code == tcce_pkg::CH_LF) begin
      put_op = tcce_pkg::OP_LF;
    end else if (in_char_code >= tcce_pkg::CH_SPACE && in_char_code <= tcce_pkg::CH_DEL) begin
      put_op = tcce_pkg::OP_PRINT;
    end else begin
      put_op = tcce_pkg::OP_NOP;
    end
  end

  // Reads beyond the buffer return zero and are handled as no operation.
  assign addr_ok = 32'(in_read_addr) < 32'(CELLS);

  // Build the queued item.
  always_comb begin
    q_item.cell_word = {in_back_color, in_fore_color, in_char_code};
    q_item.raddr     = in_read_addr;
    case (in_cmd)
      tcce_pkg::CMD_PUT:   q_item.op = put_op;
      tcce_pkg::CMD_CLEAR: q_item.op = tcce_pkg::OP_CLEAR;
      tcce_pkg::CMD_READ:  q_item.op = addr_ok ? tcce_pkg::OP_READ : tcce_pkg::OP_NOP;
      default:             q_item.op = tcce_pkg::OP_NOP;
    endcase
  end

endmodule

// ===== src/tcce_queue.sv =====
// ----------------------------------------------------------------------------
// tcce_queue: short command queue
// Decouples the front end from the back end so each side may stall alone.
// ----------------------------------------------------------------------------
module tcce_queue #(
  parameter int DEPTH = tcce_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  tcce_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output tcce_pkg::item_t pop_item,
  output logic            empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  tcce_pkg::item_t store_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [NW-1:0]   count_r;

  assign full     = (count_r == NW'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_item = store_r[rd_ptr_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== src/tcce_back.sv =====
// ----------------------------------------------------------------------------
// tcce_back: cursor and cell buffer execution unit
// Holds the cell memory and the cursor, carries out queued operations,
// sweeps the buffer for clear and reset, and copies rows up for scrolling.
// ----------------------------------------------------------------------------
module tcce_back #(
  parameter int COLUMNS  = tcce_pkg::COLUMNS_DEF,
  parameter int ROWS     = tcce_pkg::ROWS_DEF,
  parameter int TAB_STOP = tcce_pkg::TAB_STOP_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_empty,
  input  tcce_pkg::item_t             q_item,
  output logic                        q_pop,
  output logic                        out_valid,
  output logic [tcce_pkg::ADDR_W-1:0] out_cursor_pos,
  output logic [tcce_pkg::CELL_W-1:0] out_read_data
);

  localparam int CELLS         = COLUMNS * ROWS;
  localparam int AW            = $clog2(CELLS);
  localparam int CW            = $clog2(COLUMNS);
  localparam int RW            = $clog2(ROWS);
  localparam int TW            = $clog2(TAB_STOP);
  localparam int NW            = $clog2(COLUMNS + TAB_STOP);
  localparam int LAST_ROW_BASE = (ROWS - 1) * COLUMNS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_COPY,
    S_BLANK,
    S_READ0,
    S_READ1
  } state_t;

  state_t                      state_r;
  logic [CW-1:0]               col_r;
  logic [RW-1:0]               row_r;
  logic [TW-1:0]               phase_r;
  logic [AW-1:0]               pos_r;
  logic [AW-1:0]               cnt_r;
  logic                        emit_pend_r;
  logic [AW-1:0]               rd_addr_r;
  logic                        wr_en_r;
  logic [AW-1:0]               wr_addr_r;
  logic [tcce_pkg::CELL_W-1:0] wr_data_r;
  logic                        wr_from_rd_r;
  logic [tcce_pkg::CELL_W-1:0] rdata_r;
  logic                        out_valid_r;
  logic [tcce_pkg::ADDR_W-1:0] out_pos_r;
  logic [tcce_pkg::CELL_W-1:0] out_data_r;

  logic [tcce_pkg::CELL_W-1:0] mem [CELLS];
  logic [AW-1:0]               mem_raddr;
  logic [tcce_pkg::CELL_W-1:0] mem_wdata;

  logic [NW-1:0]               col_nxt;
  logic [TW-1:0]               phase_nxt;
  logic [RW-1:0]               row_nxt;
  logic [AW:0]                 pos_sum;
  logic [AW-1:0]               pos_nxt;
  logic [AW-1:0]               row_start;
  logic [NW-1:0]               tab_step;
  logic                        wrap;
  logic                        scroll;

  assign q_pop          = (state_r == S_IDLE) && !q_empty;
  assign out_valid      = out_valid_r;
  assign out_cursor_pos = out_pos_r;
  assign out_read_data  = out_data_r;

  // Cell memory: one registered write request and one registered read port.
  assign mem_raddr = (state_r == S_COPY) ? cnt_r : rd_addr_r;
  assign mem_wdata = wr_from_rd_r ? rdata_r : wr_data_r;

  always_ff @(posedge clk) begin
    if (wr_en_r) begin
      mem[wr_addr_r] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  // Cursor movement for the item at the head of the queue.
  assign tab_step  = NW'(TAB_STOP) - NW'(phase_r);
  assign row_start = pos_r - AW'(col_r);

  always_comb begin
    col_nxt   = NW'(col_r);
    phase_nxt = phase_r;
    row_nxt   = row_r;
    pos_sum   = {1'b0, pos_r};
    wrap      = 1'b0;
    scroll    = 1'b0;
    unique case (q_item.op)
      tcce_pkg::OP_PRINT: begin
        col_nxt   = NW'(col_r) + 1'b1;
        pos_sum   = {1'b0, pos_r} + 1'b1;
        phase_nxt = (phase_r == TW'(TAB_STOP - 1)) ? '0 : phase_r + 1'b1;
      end
      tcce_pkg::OP_BS: begin
        if (col_r != '0) begin
          col_nxt   = NW'(col_r) - 1'b1;
          pos_sum   = {1'b0, pos_r} - 1'b1;
          phase_nxt = (phase_r == '0) ? TW'(TAB_STOP - 1) : phase_r - 1'b1;
        end
      end
      tcce_pkg::OP_TAB: begin
        col_nxt   = NW'(col_r) + tab_step;
        pos_sum   = {1'b0, pos_r} + (AW + 1)'(tab_step);
        phase_nxt = '0;
      end
      tcce_pkg::OP_CR: begin
        col_nxt   = '0;
        pos_sum   = {1'b0, row_start};
        phase_nxt = '0;
      end
      tcce_pkg::OP_LF: begin
        wrap = 1'b1;
      end
      tcce_pkg::OP_NOP, tcce_pkg::OP_CLEAR, tcce_pkg::OP_READ: begin
      end
    endcase

    // Line end: move to the next row, or stay on the last row and scroll.
    if (col_nxt >= NW'(COLUMNS)) begin
      wrap = 1'b1;
    end
    if (wrap) begin
      col_nxt   = '0;
      phase_nxt = '0;
      if (row_r == RW'(ROWS - 1)) begin
        scroll  = 1'b1;
        pos_sum = {1'b0, row_start};
      end else begin
        row_nxt = row_r + 1'b1;
        pos_sum = {1'b0, row_start} + (AW + 1)'(COLUMNS);
      end
    end
  end

  assign pos_nxt = pos_sum[AW-1:0];

  // Sequencer state, cursor and registered result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_BLANK;
      cnt_r       <= '0;
      emit_pend_r <= 1'b0;
      col_r       <= '0;
      row_r       <= '0;
      phase_r     <= '0;
      pos_r       <= '0;
      wr_en_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      wr_en_r     <= 1'b0;
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            unique case (q_item.op)
              tcce_pkg::OP_CLEAR: begin
                col_r       <= '0;
                row_r       <= '0;
                phase_r     <= '0;
                pos_r       <= '0;
                cnt_r       <= '0;
                emit_pend_r <= 1'b1;
                state_r     <= S_BLANK;
              end
              tcce_pkg::OP_READ: begin
                rd_addr_r <= AW'(q_item.raddr);
                state_r   <= S_READ0;
              end
              tcce_pkg::OP_NOP, tcce_pkg::OP_PRINT, tcce_pkg::OP_BS, tcce_pkg::OP_TAB,
              tcce_pkg::OP_CR, tcce_pkg::OP_LF: begin
                if (q_item.op == tcce_pkg::OP_PRINT) begin
                  wr_en_r      <= 1'b1;
                  wr_addr_r    <= pos_r;
                  wr_data_r    <= q_item.cell_word;
                  wr_from_rd_r <= 1'b0;
                end
                col_r   <= CW'(col_nxt);
                row_r   <= row_nxt;
                phase_r <= phase_nxt;
                pos_r   <= pos_nxt;
                if (scroll) begin
                  cnt_r   <= AW'(COLUMNS);
                  state_r <= S_COPY;
                end else begin
                  out_valid_r <= 1'b1;
                  out_pos_r   <= tcce_pkg::ADDR_W'(pos_nxt);
                  out_data_r  <= '0;
                end
              end
            endcase
          end
        end

        // Copy each cell one row up: read this cycle, write on the next.
        S_COPY: begin
          wr_en_r      <= 1'b1;
          wr_addr_r    <= cnt_r - AW'(COLUMNS);
          wr_from_rd_r <= 1'b1;
          if (cnt_r == AW'(CELLS - 1)) begin
            cnt_r       <= AW'(LAST_ROW_BASE);
            emit_pend_r <= 1'b1;
            state_r     <= S_BLANK;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end

        // Blank from the sweep address to the end of the buffer.
        S_BLANK: begin
          wr_en_r      <= 1'b1;
          wr_addr_r    <= cnt_r;
          wr_data_r    <= tcce_pkg::BLANK_CELL;
          wr_from_rd_r <= 1'b0;
          if (cnt_r == AW'(CELLS - 1)) begin
            state_r     <= S_IDLE;
            emit_pend_r <= 1'b0;
            if (emit_pend_r) begin
              out_valid_r <= 1'b1;
              out_pos_r   <= tcce_pkg::ADDR_W'(pos_r);
              out_data_r  <= '0;
            end
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end

        // Read issued once any earlier cell write has landed.
        S_READ0: begin
          state_r <= S_READ1;
        end

        S_READ1: begin
          out_valid_r <= 1'b1;
          out_pos_r   <= tcce_pkg::ADDR_W'(pos_r);
          out_data_r  <= rdata_r;
          state_r     <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/text_console_cursor_engine.sv =====
// ----------------------------------------------------------------------------
// text_console_cursor_engine: text console cell buffer with cursor
// Results: cursor moves, printing and ignored commands report straight from
// the idle state; a cell read passes through S_READ0 and S_READ1; a put that
// scrolls and clear report at the end of one memory port pass.
// Throughput: one command per cycle while no read, clear or scroll is running.
// Reset: the cursor homes and one memory port pass blanks the buffer;
// up to the queue depth of commands are taken meanwhile. Results cannot stall.
// ----------------------------------------------------------------------------
module text_console_cursor_engine #(
  parameter int COLUMNS     = tcce_pkg::COLUMNS_DEF,
  parameter int ROWS        = tcce_pkg::ROWS_DEF,
  parameter int TAB_STOP    = tcce_pkg::TAB_STOP_DEF,
  parameter int QUEUE_DEPTH = tcce_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [tcce_pkg::CMD_W-1:0]  in_cmd,
  input  logic [tcce_pkg::CHAR_W-1:0] in_char_code,
  input  logic [tcce_pkg::COLR_W-1:0] in_back_color,
  input  logic [tcce_pkg::COLR_W-1:0] in_fore_color,
  input  logic [tcce_pkg::ADDR_W-1:0] in_read_addr,
  output logic                        out_valid,
  output logic [tcce_pkg::ADDR_W-1:0] out_cursor_pos,
  output logic [tcce_pkg::CELL_W-1:0] out_read_data
);

  logic            q_push;
  logic            q_full;
  logic            q_pop;
  logic            q_empty;
  tcce_pkg::item_t push_item;
  tcce_pkg::item_t head_item;

  // Front end: accepts and classifies commands.
  tcce_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .start         (start),
    .busy          (busy),
    .in_cmd        (in_cmd),
    .in_char_code  (in_char_code),
    .in_back_color (in_back_color),
    .in_fore_color (in_fore_color),
    .in_read_addr  (in_read_addr),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (push_item)
  );

  // Queue between the two halves.
  tcce_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (head_item),
    .empty     (q_empty)
  );

  // Back end: cursor, buffer and results.
  tcce_back #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_item         (head_item),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_cursor_pos (out_cursor_pos),
    .out_read_data  (out_read_data)
  );

endmodule

// ===== tb/text_console_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_console_checker: prediction and comparison for the console engine
// Watches the command and result channels, keeps its own copy of the cell
// buffer and cursor, and compares every result strobe with the oldest
// outstanding prediction. Mismatches are counted for the testbench top.
// ----------------------------------------------------------------------------
module text_console_checker #(
  parameter int COLUMNS  = tcce_pkg::COLUMNS_DEF,
  parameter int ROWS     = tcce_pkg::ROWS_DEF,
  parameter int TAB_STOP = tcce_pkg::TAB_STOP_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        busy,
  input  logic [tcce_pkg::CMD_W-1:0]  in_cmd,
  input  logic [tcce_pkg::CHAR_W-1:0] in_char_code,
  input  logic [tcce_pkg::COLR_W-1:0] in_back_color,
  input  logic [tcce_pkg::COLR_W-1:0] in_fore_color,
  input  logic [tcce_pkg::ADDR_W-1:0] in_read_addr,
  input  logic                        out_valid,
  input  logic [tcce_pkg::ADDR_W-1:0] out_cursor_pos,
  input  logic [tcce_pkg::CELL_W-1:0] out_read_data,
  output int                          fail_count,
  output int                          outstanding
);

  localparam int CELL_COUNT  = COLUMNS * ROWS;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [tcce_pkg::ADDR_W-1:0] cursor_pos;
    logic [tcce_pkg::CELL_W-1:0] read_data;
  } cursor_report_t;

  // Shadow copy of the cell buffer and the cursor.
  logic [tcce_pkg::CELL_W-1:0] shadow_cells [CELL_COUNT];
  int unsigned                 cur_col;
  int unsigned                 cur_row;

  // Predicted results, oldest first.
  cursor_report_t expected_reports [$];

  task automatic blank_screen();
    for (int i = 0; i < CELL_COUNT; i++) shadow_cells[i] = tcce_pkg::BLANK_CELL;
  endtask

  // Move every row up by one and blank the bottom row.
  task automatic scroll_up();
    for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) shadow_cells[i] = shadow_cells[i + COLUMNS];
    for (int i = (ROWS - 1) * COLUMNS; i < CELL_COUNT; i++) begin
      shadow_cells[i] = tcce_pkg::BLANK_CELL;
    end
    cur_row = ROWS - 1;
  endtask

  // Interpret one character byte: cursor control, printing, or nothing.
  task automatic put_character(input logic [tcce_pkg::CHAR_W-1:0] ch,
                               input logic [tcce_pkg::COLR_W-1:0] back,
                               input logic [tcce_pkg::COLR_W-1:0] fore);
    case (ch)
      tcce_pkg::CH_BS: begin
        if (cur_col != 0) cur_col--;
      end
      tcce_pkg::CH_TAB: begin
        cur_col = (cur_col / TAB_STOP + 1) * TAB_STOP;
      end
      tcce_pkg::CH_CR: begin
        cur_col = 0;
      end
      tcce_pkg::CH_LF: begin
        cur_col = 0;
        cur_row++;
      end
      default: begin
        // Only the printable range is written; other bytes leave all alone.
        if (ch >= tcce_pkg::CH_SPACE && ch <= tcce_pkg::CH_DEL) begin
          shadow_cells[cur_row * COLUMNS + cur_col] = {back, fore, ch};
          cur_col++;
        end
      end
    endcase
    if (cur_col >= COLUMNS) begin
      cur_col = 0;
      cur_row++;
    end
    if (cur_row >= ROWS) scroll_up();
  endtask

  // Apply one accepted command and work out the result it should give.
  task automatic console_apply_command(input  logic [tcce_pkg::CMD_W-1:0]  cmd,
                                       input  logic [tcce_pkg::CHAR_W-1:0] ch,
                                       input  logic [tcce_pkg::COLR_W-1:0] back,
                                       input  logic [tcce_pkg::COLR_W-1:0] fore,
                                       input  logic [tcce_pkg::ADDR_W-1:0] addr,
                                       output cursor_report_t              report);
    int unsigned pos;
    report.read_data = '0;
    case (cmd)
      tcce_pkg::CMD_PUT: begin
        put_character(ch, back, fore);
      end
      tcce_pkg::CMD_CLEAR: begin
        blank_screen();
        cur_col = 0;
        cur_row = 0;
      end
      tcce_pkg::CMD_READ: begin
        if (addr < CELL_COUNT) report.read_data = shadow_cells[addr];
      end
      default: begin
      end
    endcase
    pos = cur_row * COLUMNS + cur_col;
    report.cursor_pos = pos[tcce_pkg::ADDR_W-1:0];
  endtask

  task automatic note_failure(input string what);
    if (fail_count < MAX_REPORTS) $display("%0t: %s", $realtime, what);
    fail_count++;
  endtask

  // Results are compared before the command of the same edge is predicted:
  // no command can produce its result at the edge of its own transfer.
  always @(posedge clk) begin : watch_channels
    cursor_report_t predicted;
    cursor_report_t wanted;
    if (!rst_n) begin
      blank_screen();
      cur_col = 0;
      cur_row = 0;
      expected_reports.delete();
      fail_count = 0;
    end else begin
      if (out_valid) begin
        if (expected_reports.size() == 0) begin
          note_failure($sformatf("result with nothing outstanding: pos %0d data %h",
                                 out_cursor_pos, out_read_data));
        end else begin
          wanted = expected_reports.pop_front();
          if (out_cursor_pos !== wanted.cursor_pos || out_read_data !== wanted.read_data) begin
            note_failure($sformatf("mismatch: pos %0d data %h, expected pos %0d data %h",
                                   out_cursor_pos, out_read_data,
                                   wanted.cursor_pos, wanted.read_data));
          end
        end
      end
      if (start && !busy) begin
        console_apply_command(in_cmd, in_char_code, in_back_color, in_fore_color,
                              in_read_addr, predicted);
        expected_reports.push_back(predicted);
      end
    end
    outstanding <= expected_reports.size();
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the text console cursor engine
// Drives a short directed sequence covering cursor controls, ignored bytes,
// reads at and beyond the buffer end and clear, then random command mixes
// weighted towards printing so that wrapping and scrolling
// occur often. A checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CELL_COUNT   = tcce_pkg::COLUMNS_DEF * tcce_pkg::ROWS_DEF;
  localparam int RANDOM_ITEMS = 1950;
  localparam int QUIET_TAIL   = 300;
  localparam int SETTLE_WAIT  = 64;
  // Worst case: every command scrolls or clears, each after the longest gap.
  localparam int CYCLE_LIMIT  = (RANDOM_ITEMS + 200) * (CELL_COUNT + 40) * 3 + CELL_COUNT;

  // Command code the block does not use.
  localparam logic [tcce_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        start;
  logic                        busy;
  logic [tcce_pkg::CMD_W-1:0]  in_cmd;
  logic [tcce_pkg::CHAR_W-1:0] in_char_code;
  logic [tcce_pkg::COLR_W-1:0] in_back_color;
  logic [tcce_pkg::COLR_W-1:0] in_fore_color;
  logic [tcce_pkg::ADDR_W-1:0] in_read_addr;
  logic                        out_valid;
  logic [tcce_pkg::ADDR_W-1:0] out_cursor_pos;
  logic [tcce_pkg::CELL_W-1:0] out_read_data;
  int                          fail_count;
  int                          outstanding;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  text_console_cursor_engine dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_cmd         (in_cmd),
    .in_char_code   (in_char_code),
    .in_back_color  (in_back_color),
    .in_fore_color  (in_fore_color),
    .in_read_addr   (in_read_addr),
    .out_valid      (out_valid),
    .out_cursor_pos (out_cursor_pos),
    .out_read_data  (out_read_data)
  );

  text_console_checker checker_inst (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_cmd         (in_cmd),
    .in_char_code   (in_char_code),
    .in_back_color  (in_back_color),
    .in_fore_color  (in_fore_color),
    .in_read_addr   (in_read_addr),
    .out_valid      (out_valid),
    .out_cursor_pos (out_cursor_pos),
    .out_read_data  (out_read_data),
    .fail_count     (fail_count),
    .outstanding    (outstanding)
  );

  // Present one command and hold it until the edge at which it transfers.
  task automatic send_command(input logic [tcce_pkg::CMD_W-1:0]  cmd,
                              input logic [tcce_pkg::CHAR_W-1:0] ch,
                              input logic [tcce_pkg::COLR_W-1:0] back,
                              input logic [tcce_pkg::COLR_W-1:0] fore,
                              input logic [tcce_pkg::ADDR_W-1:0] addr);
    in_cmd        <= cmd;
    in_char_code  <= ch;
    in_back_color <= back;
    in_fore_color <= fore;
    in_read_addr  <= addr;
    start         <= 1'b1;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  // Stimulus.
  initial begin
    int unsigned                 pick;
    int unsigned                 useful;
    bit                          counts;
    logic [tcce_pkg::CMD_W-1:0]  cmd;
    logic [tcce_pkg::CHAR_W-1:0] ch;
    logic [tcce_pkg::COLR_W-1:0] back;
    logic [tcce_pkg::COLR_W-1:0] fore;
    logic [tcce_pkg::ADDR_W-1:0] addr;

    rst_n         <= 1'b0;
    start         <= 1'b0;
    in_cmd        <= tcce_pkg::CMD_PUT;
    in_char_code  <= '0;
    in_back_color <= '0;
    in_fore_color <= '0;
    in_read_addr  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reads of the blank buffer, including past its end.
    send_command(tcce_pkg::CMD_READ, 8'h00, 4'h0, 4'h0, 11'd0);
    send_command(tcce_pkg::CMD_READ, 8'hFF, 4'hF, 4'hF, tcce_pkg::ADDR_W'(CELL_COUNT - 1));
    send_command(tcce_pkg::CMD_READ, 8'h00, 4'h0, 4'h0, tcce_pkg::ADDR_W'(CELL_COUNT));
    send_command(tcce_pkg::CMD_READ, 8'h00, 4'h0, 4'h0, 11'h7FF);
    // Printable extremes with extreme colours.
    send_command(tcce_pkg::CMD_PUT, tcce_pkg::CH_SPACE, 4'h0, 4'h0, 11'd0);
    send_command(tcce_pkg::CMD_PUT, tcce_pkg::CH_DEL, 4'hF, 4'hF, 11'h7FF);
    send_command(tcce_pkg::CMD_PUT, 8'h41, 4'h5, 4'hA, 11'd0);
    // Bytes that are ignored.
    send_command(tcce_pkg::CMD_PUT, 8'h00, 4'h3, 4'h3, 11'd0);
    send_command(tcce_pkg::CMD_PUT, 8'h1F, 4'h3, 4'h3, 11'd0);
    send_command(tcce_pkg::CMD_PUT, 8'h80, 4'h3, 4'h3, 11'd0);
    send_command(tcce_pkg::CMD_PUT, 8'hFF, 4'h3, 4'h3, 11'd0);
    // Backspace down to column zero and once more there.
    repeat (4) send_command(tcce_pkg::CMD_PUT, tcce_pkg::CH_BS, 4'h0, 4'h0, 11'd0);
    send_command(tcce_pkg::CMD_PUT, tcce_pkg::CH_TAB, 4'h0, 4'h0, 11'd0);
    send_command(tcce_pkg::CMD_PUT, tcce_pkg::CH_TAB, 4'h0, 4'h0, 11'd0);
    send_command(tcce_pkg::CMD_PUT, tcce_pkg::CH_CR, 4'h0, 4'h0, 11'd0);
    send_command(tcce_pkg::CMD_PUT, tcce_pkg::CH_LF, 4'h0, 4'h0, 11'd0);
    send_command(CMD_UNUSED, 8'hFF, 4'hF, 4'hF, 11'h7FF);
    send_command(tcce_pkg::CMD_READ, 8'h00, 4'h0, 4'h0, 11'd0);
    send_command(tcce_pkg::CMD_READ, 8'h00, 4'h0, 4'h0, 11'd1);
    send_command(tcce_pkg::CMD_READ, 8'h00, 4'h0, 4'h0, 11'd2);
    send_command(tcce_pkg::CMD_CLEAR, 8'hAA, 4'hA, 4'h5, 11'h555);
    send_command(tcce_pkg::CMD_READ, 8'h00, 4'h0, 4'h0, 11'd1);

    // Random part: mostly printing and line feeds, so the screen fills and
    // scrolls; reads lean towards the bottom rows where writing happens.
    useful = 0;
    while (useful < RANDOM_ITEMS) begin
      pick   = $urandom_range(0, 999);
      cmd    = tcce_pkg::CMD_PUT;
      ch     = tcce_pkg::CHAR_W'($urandom);
      back   = tcce_pkg::COLR_W'($urandom);
      fore   = tcce_pkg::COLR_W'($urandom);
      addr   = tcce_pkg::ADDR_W'($urandom);
      counts = 1'b1;
      if (pick < 600) begin
        ch = tcce_pkg::CHAR_W'($urandom_range(tcce_pkg::CH_SPACE, tcce_pkg::CH_DEL));
      end else if (pick < 650) begin
        ch = tcce_pkg::CH_LF;
      end else if (pick < 680) begin
        ch = tcce_pkg::CH_CR;
      end else if (pick < 720) begin
        ch = tcce_pkg::CH_TAB;
      end else if (pick < 760) begin
        ch = tcce_pkg::CH_BS;
      end else if (pick < 800) begin
        counts = 1'b0;
      end else if (pick < 980) begin
        cmd = tcce_pkg::CMD_READ;
        if (pick < 900) begin
          addr = tcce_pkg::ADDR_W'($urandom_range(CELL_COUNT - 2 * tcce_pkg::COLUMNS_DEF,
                                                  CELL_COUNT - 1));
        end else if (pick < 960) begin
          addr = tcce_pkg::ADDR_W'($urandom_range(0, CELL_COUNT - 1));
        end
      end else if (pick < 983) begin
        cmd = tcce_pkg::CMD_CLEAR;
      end else begin
        cmd    = CMD_UNUSED;
        counts = 1'b0;
      end
      send_command(cmd, ch, back, fore, addr);
      if (counts) useful++;
      // Sender gaps in bursts, none in the closing stretch.
      if (useful < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 7) == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
    end
    start <= 1'b0;
    @(posedge clk);

    // Drain outstanding results, then watch for stray strobes a little longer.
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("testbench: done, errors");
    $finish;
  end

endmodule
